### rtl/core/ray_free_cell_walker_unit_macros.svh
// ----------------------------------------------------------------------------
// Ray free-cell walker assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef RAY_FREE_CELL_WALKER_UNIT_MACROS_SVH
`define RAY_FREE_CELL_WALKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RFCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RFCW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `RFCW_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define RFCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFCW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/rfcw_pkg.sv
// ----------------------------------------------------------------------------
// Ray free-cell walker package
// Payload types, ray command descriptor and fixed sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rfcw_pkg;

    localparam int COORD_W     = 6;
    localparam int MAX_RESULTS = 63;
    localparam int CNT_W       = 6;
    localparam int ERR_W       = 9;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [0:0] REG_START_X = 1'b0;
    localparam logic [0:0] REG_START_Y = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } t_ray_req;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               cell_valid;
        logic               last;
    } t_cell_res;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic               sx_pos;
        logic               sy_pos;
        logic               empty;
    } t_ray_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

`default_nettype wire

### rtl/core/rfcw_front.sv
// ----------------------------------------------------------------------------
// Ray free-cell walker front end
// Clamps coordinates and classifies one detection into a ray command.
// ----------------------------------------------------------------------------
`default_nettype none

module rfcw_front #(
    parameter int GRID_CELLS = 64
) (
    input  rfcw_pkg::t_ray_req                  i_req,
    input  logic [rfcw_pkg::COORD_W-1:0]        i_start_x,
    input  logic [rfcw_pkg::COORD_W-1:0]        i_start_y,
    output rfcw_pkg::t_ray_cmd                  o_cmd
);
    import rfcw_pkg::*;

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_CELLS - 1);

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        clamp = (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;

    always_comb begin
        x0 = clamp(i_start_x);
        y0 = clamp(i_start_y);
        tx = clamp(i_req.target_x);
        ty = clamp(i_req.target_y);
        o_cmd.x0     = x0;
        o_cmd.y0     = y0;
        o_cmd.tx     = tx;
        o_cmd.ty     = ty;
        o_cmd.dx     = (tx > x0) ? tx - x0 : x0 - tx;
        o_cmd.dy     = (ty > y0) ? ty - y0 : y0 - ty;
        o_cmd.sx_pos = (x0 < tx);
        o_cmd.sy_pos = (y0 < ty);
        o_cmd.empty  = (x0 == tx) && (y0 == ty);
    end

endmodule

`default_nettype wire

### rtl/core/rfcw_fifo.sv
// ----------------------------------------------------------------------------
// Ray free-cell walker command queue
// Short queue of ray commands between front end and walker.
// ----------------------------------------------------------------------------
`default_nettype none

module rfcw_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfcw_pkg::t_ray_cmd  i_cmd,
    input  logic                i_pop,
    output rfcw_pkg::t_ray_cmd  o_cmd,
    output rfcw_pkg::t_fifo_stat o_stat
);
    import rfcw_pkg::*;

    t_ray_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_cnt;
    logic [FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  n_cnt;
    logic                   do_push;
    logic                   do_pop;

    function automatic logic [FIFO_PTR_W-1:0] bump(input logic [FIFO_PTR_W-1:0] p);
        bump = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        o_stat.full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
        o_stat.empty = (r_cnt == '0);
        do_push  = i_push && !o_stat.full;
        do_pop   = i_pop && !o_stat.empty;
        n_wr_ptr = do_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? bump(r_rd_ptr) : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
        o_cmd = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rfcw_back.sv
// ----------------------------------------------------------------------------
// Ray free-cell walker back end
// Bresenham error loop: one cell per unstalled cycle into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfcw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfcw_pkg::t_ray_cmd   i_cmd,
    input  rfcw_pkg::t_fifo_stat i_stat,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rfcw_pkg::t_cell_res  o_out_data
);
    import rfcw_pkg::*;

    logic                      r_busy;
    t_ray_cmd                  r_cmd;
    logic [COORD_W-1:0]        r_x;
    logic [COORD_W-1:0]        r_y;
    logic signed [ERR_W-1:0]   r_err;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;
    t_cell_res                 r_out;

    logic                      n_busy;
    logic [COORD_W-1:0]        n_x;
    logic [COORD_W-1:0]        n_y;
    logic signed [ERR_W-1:0]   n_err;
    logic [CNT_W-1:0]          n_cnt;
    logic                      n_out_valid;
    t_cell_res                 n_out;

    logic                      slot_free;
    logic                      produce;
    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W:0]     dx_s;
    logic signed [ERR_W:0]     dy_s;
    logic                      x_step;
    logic                      y_step;
    logic                      done;

    always_comb begin
        slot_free = !r_out_valid || !i_out_stall;
        o_pop     = !r_busy && !i_stat.empty;
        produce   = r_busy && slot_free;

        e2     = {r_err, 1'b0};
        dx_s   = signed'({{(ERR_W + 1 - COORD_W){1'b0}}, r_cmd.dx});
        dy_s   = signed'({{(ERR_W + 1 - COORD_W){1'b0}}, r_cmd.dy});
        x_step = (e2 >= -dy_s);
        y_step = (e2 <= dx_s);

        n_x = r_x;
        if (x_step) begin
            n_x = r_cmd.sx_pos ? r_x + 1'b1 : r_x - 1'b1;
        end
        n_y = r_y;
        if (y_step) begin
            n_y = r_cmd.sy_pos ? r_y + 1'b1 : r_y - 1'b1;
        end
        n_err = r_err - (x_step ? ERR_W'(dy_s) : '0) + (y_step ? ERR_W'(dx_s) : '0);
        done  = ((n_x == r_cmd.tx) && (n_y == r_cmd.ty))
              || (r_cnt == CNT_W'(MAX_RESULTS - 1));
        n_cnt = r_cnt + 1'b1;

        n_busy      = r_busy;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (o_pop) begin
            n_busy = 1'b1;
        end else if (produce) begin
            n_out_valid = 1'b1;
            if (r_cmd.empty) begin
                n_out  = '{cell_x: '0, cell_y: '0, cell_valid: 1'b0, last: 1'b1};
                n_busy = 1'b0;
            end else begin
                n_out  = '{cell_x: r_x, cell_y: r_y, cell_valid: 1'b1, last: done};
                n_busy = !done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_x   <= i_cmd.x0;
            r_y   <= i_cmd.y0;
            r_err <= ERR_W'(i_cmd.dx) - ERR_W'(i_cmd.dy);
            r_cnt <= '0;
        end else if (produce) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
            r_cnt <= n_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### rtl/core/ray_free_cell_walker_unit.sv
// ----------------------------------------------------------------------------
// Ray free-cell walker
// Emits every grid cell on the Bresenham line from the start cell toward a
// detection cell, the detection cell excluded.
//
// Input channel: one request per detection (target_x, target_y), taken when
// i_in_valid is high and o_in_stall is low. Output channel: one result per
// free cell, in walk order, last set on the final cell of a ray. A ray whose
// target equals the start yields one result with cell_valid low and last set.
// A queued request is popped into the walker when idle; it then registers one
// cell per cycle in its output register while the receiver does not stall,
// at most 63 per ray, and pops again only after a ray's last result. A
// two-entry command queue lets requests be taken while a ray is walked. When
// the receiver stalls, the output register holds its result and the walker
// pauses; the queue fills and then o_in_stall rises. Reset clears the queue,
// the walker and the output valid, and sets both start registers to 32.
// Start registers sit at byte addresses 0 and 4 of the APB port; the user
// must write them only while no ray is outstanding, not enforced by the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_free_cell_walker_unit_macros.svh"

module ray_free_cell_walker_unit #(
    parameter int GRID_CELLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rfcw_pkg::t_ray_req   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rfcw_pkg::t_cell_res  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rfcw_pkg::*;

    logic [COORD_W-1:0] r_start_x;
    logic [COORD_W-1:0] r_start_y;
    logic               cfg_wr;
    t_ray_cmd           front_cmd;
    t_ray_cmd           queue_cmd;
    t_fifo_stat         queue_stat;
    logic               queue_pop;
    logic               empty_res;
    logic               cell_nz;
    logic               mid_take;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= COORD_W'(32);
            r_start_y <= COORD_W'(32);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_START_X: r_start_x <= pwdata[COORD_W-1:0];
                REG_START_Y: r_start_y <= pwdata[COORD_W-1:0];
                default:     r_start_x <= r_start_x;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START_X: prdata = {{(32 - COORD_W){1'b0}}, r_start_x};
            REG_START_Y: prdata = {{(32 - COORD_W){1'b0}}, r_start_y};
            default:     prdata = '0;
        endcase
    end

    rfcw_front #(
        .GRID_CELLS(GRID_CELLS)
    ) u_front (
        .i_req     (i_in_data),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .o_cmd     (front_cmd)
    );

    rfcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (front_cmd),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd),
        .o_stat  (queue_stat)
    );

    assign o_in_stall = queue_stat.full;

    rfcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_stat      (queue_stat),
        .o_pop       (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    assign empty_res = o_out_valid && !o_out_data.cell_valid;
    assign cell_nz   = (o_out_data.cell_x != '0) || (o_out_data.cell_y != '0);
    assign mid_take  = o_out_valid && !i_out_stall && !o_out_data.last;

    `RFCW_ASSERT(a_empty_is_last, i_clk, i_rst_n, empty_res |-> o_out_data.last, "empty not last")
    `RFCW_ASSERT_NEVER(a_empty_is_zero, i_clk, i_rst_n, empty_res && cell_nz, "empty with cell")
    `RFCW_ASSERT(a_ray_continues, i_clk, i_rst_n, mid_take |=> o_out_valid, "gap in ray")

endmodule

`default_nettype wire
